>>> rtl/rsa_pkg.sv
package rsa_pkg;

  // Field widths of the request and result beats
  localparam int unsigned SLOT_FIELD_W = 6;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned STATUS_W     = 2;

  localparam int unsigned NUM_SLOTS_DEF = 64;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOT_BUSY = 2'd2
  } rsa_status_e;

  // Memory strobes from the controller
  typedef struct packed {
    logic rd_en;
    logic q_wr_en;
    logic t_wr_en;
  } rsa_mem_ctl_t;

endpackage

>>> rtl/rsa_ram.sv
module rsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/rsa_ctrl.sv
module rsa_ctrl import rsa_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_wr_en_i,
  input  logic [ID_W-1:0]                      cfg_wr_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic [ID_W-1:0]                      query_id_i,
  input  logic [SLOT_FIELD_W-1:0]              slot_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [SLOT_FIELD_W-1:0]              granted_slot_o,
  output logic [ID_W-1:0]                      transaction_id_o,
  output logic [STATUS_W-1:0]                  status_o,
  output rsa_mem_ctl_t                         mem_ctl_o,
  output logic [$clog2(NUM_SLOTS)-1:0]         q_rd_addr_o,
  output logic [$clog2(NUM_SLOTS)-1:0]         q_wr_addr_o,
  output logic [$clog2(NUM_SLOTS)-1:0]         q_wr_data_o,
  input  logic [$clog2(NUM_SLOTS)-1:0]         q_rd_data_i,
  output logic [$clog2(NUM_SLOTS)-1:0]         t_rd_addr_o,
  output logic [$clog2(NUM_SLOTS)-1:0]         t_wr_addr_o,
  output logic [2*ID_W:0]                      t_wr_data_o,
  input  logic [2*ID_W:0]                      t_rd_data_i
);

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned EXT_W  = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned TBL_W  = 2 * ID_W + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                   state_q, state_d;
  logic                     kind_q, kind_d;
  logic [ID_W-1:0]          qid_q, qid_d;
  logic [SLOT_FIELD_W-1:0]  slot_q, slot_d;
  logic [SLOT_W-1:0]        head_q, head_d;
  logic [SLOT_W-1:0]        tail_q, tail_d;
  logic                     head_wrap_q, head_wrap_d;
  logic                     tail_wrap_q, tail_wrap_d;
  logic [CNT_W-1:0]         free_cnt_q, free_cnt_d;
  logic [ID_W-1:0]          next_id_q, next_id_d;
  logic                     out_valid_q, out_valid_d;
  logic [SLOT_FIELD_W-1:0]  out_slot_q, out_slot_d;
  logic [ID_W-1:0]          out_tid_q, out_tid_d;
  logic [STATUS_W-1:0]      out_status_q, out_status_d;

  logic              accept, exec_fire;
  logic [EXT_W-1:0]  in_ext, slot_ext, taken_ext;
  logic [SLOT_W-1:0] slot_idx, taken;
  logic              in_range, ever_alloc, busy, alloc_ok, rel_ok;

  function automatic logic [SLOT_W-1:0] advance(input logic [SLOT_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign in_ext = EXT_W'(slot_i);

  // Current item fields
  assign slot_ext = EXT_W'(slot_q);
  assign slot_idx = slot_ext[SLOT_W-1:0];
  assign in_range = {1'b0, slot_ext} < (EXT_W + 1)'(NUM_SLOTS);

  // Queue entries not yet reached by the tail on its first pass still hold their index
  assign taken     = (!tail_wrap_q && (head_q >= tail_q)) ? head_q : q_rd_data_i;
  assign taken_ext = EXT_W'(taken);

  // A slot's table entry is meaningful once the slot has been handed out
  assign ever_alloc = head_wrap_q || (slot_idx < head_q);
  assign busy       = in_range && ever_alloc && t_rd_data_i[TBL_W-1];

  assign alloc_ok  = (kind_q == KIND_ALLOC) && (free_cnt_q != '0);
  assign rel_ok    = (kind_q == KIND_RELEASE) && busy && (free_cnt_q < CNT_W'(NUM_SLOTS));
  assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    mem_ctl_o.rd_en   = accept;
    mem_ctl_o.q_wr_en = exec_fire && rel_ok;
    mem_ctl_o.t_wr_en = exec_fire && (alloc_ok || rel_ok);
  end

  assign q_rd_addr_o = head_q;
  assign t_rd_addr_o = in_ext[SLOT_W-1:0];
  assign q_wr_addr_o = tail_q;
  assign q_wr_data_o = slot_idx;
  assign t_wr_addr_o = (kind_q == KIND_ALLOC) ? taken : slot_idx;
  assign t_wr_data_o = (kind_q == KIND_ALLOC) ? {1'b1, qid_q, next_id_q} : '0;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    qid_d        = qid_q;
    slot_d       = slot_q;
    head_d       = head_q;
    tail_d       = tail_q;
    head_wrap_d  = head_wrap_q;
    tail_wrap_d  = tail_wrap_q;
    free_cnt_d   = free_cnt_q;
    next_id_d    = next_id_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_slot_d   = out_slot_q;
    out_tid_d    = out_tid_q;
    out_status_d = out_status_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d  = kind_i;
          qid_d   = query_id_i;
          slot_d  = slot_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_tid_d   = '0;
          if (kind_q == KIND_ALLOC) begin
            if (alloc_ok) begin
              out_slot_d   = taken_ext[SLOT_FIELD_W-1:0];
              out_tid_d    = next_id_q;
              out_status_d = STATUS_OK;
              head_d       = advance(head_q);
              head_wrap_d  = head_wrap_q || (head_q == LAST_SLOT);
              free_cnt_d   = free_cnt_q - 1'b1;
              next_id_d    = next_id_q + 1'b1;
            end else begin
              out_slot_d   = '0;
              out_status_d = STATUS_FULL;
            end
          end else begin
            out_slot_d = slot_q;
            if (rel_ok) begin
              out_status_d = STATUS_OK;
              tail_d       = advance(tail_q);
              tail_wrap_d  = tail_wrap_q || (tail_q == LAST_SLOT);
              free_cnt_d   = free_cnt_q + 1'b1;
            end else begin
              out_status_d = STATUS_NOT_BUSY;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_wr_en_i) begin
      next_id_d = cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      head_wrap_q  <= 1'b0;
      tail_wrap_q  <= 1'b0;
      free_cnt_q   <= CNT_W'(NUM_SLOTS);
      next_id_q    <= '0;
      out_valid_q  <= 1'b0;
      kind_q       <= KIND_ALLOC;
      qid_q        <= '0;
      slot_q       <= '0;
      out_slot_q   <= '0;
      out_tid_q    <= '0;
      out_status_q <= STATUS_OK;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      head_wrap_q  <= head_wrap_d;
      tail_wrap_q  <= tail_wrap_d;
      free_cnt_q   <= free_cnt_d;
      next_id_q    <= next_id_d;
      out_valid_q  <= out_valid_d;
      kind_q       <= kind_d;
      qid_q        <= qid_d;
      slot_q       <= slot_d;
      out_slot_q   <= out_slot_d;
      out_tid_q    <= out_tid_d;
      out_status_q <= out_status_d;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign granted_slot_o   = out_slot_q;
  assign transaction_id_o = out_tid_q;
  assign status_o         = out_status_q;

endmodule

>>> rtl/request_slot_allocator_top.sv
// A request is accepted in the idle state; its result beat is registered in the output register
//   from the execute state, which waits while a held result is stalled. No new request is taken
//   until then; both memories are read at acceptance and written back from the execute state.
// A finished result waits in the output register while the next request is taken.
// Reset: asynchronous, active low; the pool is usable at once, with no clearing pass.
module request_slot_allocator_top import rsa_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_wr_en_i,
  input  logic [ID_W-1:0]         cfg_wr_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic [ID_W-1:0]         query_id_i,
  input  logic [SLOT_FIELD_W-1:0] slot_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SLOT_FIELD_W-1:0] granted_slot_o,
  output logic [ID_W-1:0]         transaction_id_o,
  output logic [STATUS_W-1:0]     status_o
);

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned TBL_W  = 2 * ID_W + 1;

  rsa_mem_ctl_t      mem_ctl;
  logic [SLOT_W-1:0] q_rd_addr, q_wr_addr, q_wr_data, q_rd_data;
  logic [SLOT_W-1:0] t_rd_addr, t_wr_addr;
  logic [TBL_W-1:0]  t_wr_data, t_rd_data;

  // Sequencer: pointers, free count, id counter and the read-modify-write of both memories
  rsa_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .query_id_i       (query_id_i),
    .slot_i           (slot_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .granted_slot_o   (granted_slot_o),
    .transaction_id_o (transaction_id_o),
    .status_o         (status_o),
    .mem_ctl_o        (mem_ctl),
    .q_rd_addr_o      (q_rd_addr),
    .q_wr_addr_o      (q_wr_addr),
    .q_wr_data_o      (q_wr_data),
    .q_rd_data_i      (q_rd_data),
    .t_rd_addr_o      (t_rd_addr),
    .t_wr_addr_o      (t_wr_addr),
    .t_wr_data_o      (t_wr_data),
    .t_rd_data_i      (t_rd_data)
  );

  // Free list of slot numbers; entries the tail has not yet reached read as their own index
  rsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUM_SLOTS)
  ) u_free_queue (
    .clk_i     (clk_i),
    .wr_en_i   (mem_ctl.q_wr_en),
    .wr_addr_i (q_wr_addr),
    .wr_data_i (q_wr_data),
    .rd_en_i   (mem_ctl.rd_en),
    .rd_addr_i (q_rd_addr),
    .rd_data_o (q_rd_data)
  );

  // Slot table: busy mark, query id and transaction id per slot
  rsa_ram #(
    .WIDTH (TBL_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_table (
    .clk_i     (clk_i),
    .wr_en_i   (mem_ctl.t_wr_en),
    .wr_addr_i (t_wr_addr),
    .wr_data_i (t_wr_data),
    .rd_en_i   (mem_ctl.rd_en),
    .rd_addr_i (t_rd_addr),
    .rd_data_o (t_rd_data)
  );

  // A failed request never carries a transaction id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_OK)) |-> (transaction_id_o == '0))
    else $error("failed request carries a transaction id");

  // A free-queue push always comes with a slot-table update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.q_wr_en |-> mem_ctl.t_wr_en)
    else $error("free-queue push without slot-table update");

  // A slot-table write follows a read, or an execute cycle that was stalled with no write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.t_wr_en |-> $past(mem_ctl.rd_en) || $past(mem_ctl.t_wr_en == 1'b0 && in_stall_o))
    else $error("slot-table write without a preceding read");

  // An accepted request raises the input stall, holding off the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while the previous one is still in flight");

endmodule
